### rtl/tpms_pkg.sv
// Shared types and constants for the two-pattern span search block.
`default_nettype none

package tpms_pkg;

    localparam int PAT_W     = 64;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 8;
    localparam int SPAN_W    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PATTERN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LENGTH   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PATTERN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LENGTH  = 8'd3;

    localparam logic signed [SPAN_W-1:0] SPAN_NONE = -10'sd1;
    localparam logic [SPAN_W-1:0]        SPAN_MAX  = 10'd511;

    typedef struct packed {
        logic [PAT_W-1:0] first_pattern;
        logic [LEN_W-1:0] first_length;
        logic [PAT_W-1:0] second_pattern;
        logic [LEN_W-1:0] second_length;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/tpms_cfg_regs.sv
// Configuration register file holding both patterns and their lengths.
`default_nettype none

module tpms_cfg_regs
    import tpms_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PAT_W-1:0]     cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_pattern  <= '0;
            cfg_reg.first_length   <= LEN_W'(1);
            cfg_reg.second_pattern <= '0;
            cfg_reg.second_length  <= LEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FIRST_PATTERN:  cfg_reg.first_pattern  <= cfg_data;
                CFG_FIRST_LENGTH:   cfg_reg.first_length   <= cfg_data[LEN_W-1:0];
                CFG_SECOND_PATTERN: cfg_reg.second_pattern <= cfg_data;
                CFG_SECOND_LENGTH:  cfg_reg.second_length  <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/tpms_matcher.sv
// Parallel window compare of one pattern against the most recent text bytes.
`default_nettype none

module tpms_matcher
    import tpms_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int IDX_W       = 9
)
(
    input  wire logic [PAT_W-1:0] pattern,
    input  wire logic [LEN_W-1:0] length,
    input  wire logic [7:0]       window [MAX_PATTERN],
    input  wire logic [IDX_W-1:0] pos,
    output logic                  hit,
    output logic [IDX_W-1:0]      start
);

    localparam int CW = IDX_W + 1;

    logic [LEN_W-1:0]       eff_len;
    logic [MAX_PATTERN-1:0] len_hit;
    logic                   sel_hit;
    logic [CW-1:0]          seen;

    always_comb
    begin
        if (length == '0)
            eff_len = LEN_W'(1);
        else if (length > LEN_W'(MAX_PATTERN))
            eff_len = LEN_W'(MAX_PATTERN);
        else
            eff_len = length;
    end

    // Window entry zero is the newest byte, so the pattern's first byte
    // sits at the oldest position of a candidate match.
    always_comb
    begin
        for (int n = 0; n < MAX_PATTERN; n++)
        begin
            len_hit[n] = 1'b1;
            for (int i = 0; i <= n; i++)
            begin
                if (window[n - i] != pattern[8*i +: 8])
                    len_hit[n] = 1'b0;
            end
        end
    end

    always_comb
    begin
        sel_hit = 1'b0;
        for (int n = 0; n < MAX_PATTERN; n++)
        begin
            if (eff_len == LEN_W'(n + 1))
                sel_hit = len_hit[n];
        end
    end

    assign seen  = CW'(pos) + CW'(1);
    assign hit   = sel_hit && (seen >= CW'(eff_len));
    assign start = IDX_W'(seen - CW'(eff_len));

endmodule

`default_nettype wire

### rtl/two_pattern_max_span_unit.sv
// Two-pattern span search: one text byte per cycle, one result per text;
// input stalls only while a final byte waits on an untaken result.
// Throughput: one byte per cycle, set by the single-pass window compare
// between the input register and the state and result registers.
// Reset: asynchronous and active low; it sets both patterns to zero with
// length one and clears the text position, match records and overflow flag.
`default_nettype none

module two_pattern_max_span_unit
    import tpms_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_TEXT    = 512
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [7:0]               text_byte,
    input  wire logic                     final_byte,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [SPAN_W-1:0]      span,
    output logic                          overflow,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [PAT_W-1:0]         cfg_data
);

    localparam int IDX_W = $clog2(MAX_TEXT);
    localparam int POS_W = $clog2(MAX_TEXT + 1);
    localparam int SW    = (IDX_W > SPAN_W) ? IDX_W : SPAN_W;

    cfg_t cfg;

    logic             in_vld_reg;
    logic [7:0]       in_byte_reg;
    logic             in_final_reg;

    logic [7:0]       window_reg  [MAX_PATTERN];
    logic [7:0]       window_next [MAX_PATTERN];
    logic [POS_W-1:0] pos_reg;
    logic             left_found_reg;
    logic [IDX_W-1:0] left_end_reg;
    logic             right_found_reg;
    logic [IDX_W-1:0] right_start_reg;
    logic             overflowed_reg;

    logic                     out_vld_reg;
    logic signed [SPAN_W-1:0] span_reg;
    logic                     overflow_reg;

    logic             adv;
    logic             in_range;
    logic [IDX_W-1:0] pos_idx;
    logic             left_hit;
    logic [IDX_W-1:0] left_start_unused;
    logic             right_hit;
    logic [IDX_W-1:0] right_start_hit;

    logic             left_found_next;
    logic [IDX_W-1:0] left_end_next;
    logic             right_found_next;
    logic [IDX_W-1:0] right_start_next;
    logic             overflowed_next;
    logic [SW-1:0]    diff;
    logic signed [SPAN_W-1:0] span_next;

    tpms_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        window_next[0] = in_byte_reg;
        for (int k = 1; k < MAX_PATTERN; k++)
            window_next[k] = window_reg[k - 1];
    end

    assign in_range = pos_reg < POS_W'(MAX_TEXT);
    assign pos_idx  = pos_reg[IDX_W-1:0];

    tpms_matcher #(
        .MAX_PATTERN (MAX_PATTERN),
        .IDX_W       (IDX_W)
    ) u_left (
        .pattern (cfg.first_pattern),
        .length  (cfg.first_length),
        .window  (window_next),
        .pos     (pos_idx),
        .hit     (left_hit),
        .start   (left_start_unused)
    );

    tpms_matcher #(
        .MAX_PATTERN (MAX_PATTERN),
        .IDX_W       (IDX_W)
    ) u_right (
        .pattern (cfg.second_pattern),
        .length  (cfg.second_length),
        .window  (window_next),
        .pos     (pos_idx),
        .hit     (right_hit),
        .start   (right_start_hit)
    );

    // The left record keeps the first match; the right record follows the latest.
    always_comb
    begin
        left_found_next  = left_found_reg;
        left_end_next    = left_end_reg;
        right_found_next = right_found_reg;
        right_start_next = right_start_reg;
        overflowed_next  = overflowed_reg;
        if (!in_range)
        begin
            overflowed_next = 1'b1;
        end
        else
        begin
            if (!left_found_reg && left_hit && (left_start_unused <= pos_idx))
            begin
                left_found_next = 1'b1;
                left_end_next   = pos_idx;
            end
            if (right_hit)
            begin
                right_found_next = 1'b1;
                right_start_next = right_start_hit;
            end
        end
    end

    always_comb
    begin
        diff = SW'(right_start_next) - SW'(left_end_next) - SW'(1);
        if (left_found_next && right_found_next && (right_start_next > left_end_next))
        begin
            if (diff > SW'(SPAN_MAX))
                span_next = signed'(SPAN_MAX);
            else
                span_next = signed'(SPAN_W'(diff));
        end
        else
        begin
            span_next = SPAN_NONE;
        end
    end

    assign adv      = in_vld_reg && !(in_final_reg && out_vld_reg && !out_ready);
    assign in_ready = !in_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg  <= text_byte;
            in_final_reg <= final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
                window_reg[k] <= '0;
            pos_reg         <= '0;
            left_found_reg  <= 1'b0;
            left_end_reg    <= '0;
            right_found_reg <= 1'b0;
            right_start_reg <= '0;
            overflowed_reg  <= 1'b0;
        end
        else if (adv)
        begin
            if (in_range)
            begin
                for (int k = 0; k < MAX_PATTERN; k++)
                    window_reg[k] <= window_next[k];
            end
            if (in_final_reg)
            begin
                pos_reg         <= '0;
                left_found_reg  <= 1'b0;
                left_end_reg    <= '0;
                right_found_reg <= 1'b0;
                right_start_reg <= '0;
                overflowed_reg  <= 1'b0;
            end
            else
            begin
                if (in_range)
                    pos_reg <= pos_reg + POS_W'(1);
                left_found_reg  <= left_found_next;
                left_end_reg    <= left_end_next;
                right_found_reg <= right_found_next;
                right_start_reg <= right_start_next;
                overflowed_reg  <= overflowed_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv && in_final_reg)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_final_reg)
        begin
            span_reg     <= span_next;
            overflow_reg <= overflowed_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign span      = span_reg;
    assign overflow  = overflow_reg;

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_TEXT))
        else $error("Text position ran past its saturation point.");

    a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        adv && in_final_reg |=> pos_reg == '0 && !left_found_reg && !right_found_reg
            && !overflowed_reg)
        else $error("Per-text state was not cleared after a final byte.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_vld_reg && !out_ready && in_final_reg)
        else $error("Input stalled without a pending result transfer.");

    a_span_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (span_reg == SPAN_NONE) || !span_reg[SPAN_W-1])
        else $error("Span result is negative but not the no-match code.");
`endif

endmodule

`default_nettype wire
